// File: design/sm3_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 package
// Constants, types and round helper functions shared by the SM3 hash core.
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  localparam logic [31:0] IV [8] = '{
    32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
    32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_EXP,
    ST_ROUND,
    ST_FOLD,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_beat_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// File: design/sm3_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SM3 stream interfaces
// Valid/ready channels for message bytes and digest words.
// ----------------------------------------------------------------------------
interface sm3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  modport source (output valid, data_byte, byte_valid, last, input ready);
  modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// File: design/sm3_hash_core.sv
`timescale 1ns / 1ps
// A byte that does not fill a block, and is not the last, is written to the block buffer in idle.
// A full block goes through 16 word loads, 52 expansion steps through the word memory,
// 64 rounds and one fold. A last item adds padding at one cycle per byte, one or two
// compressions, then eight beats.
// Throughput is set mostly by the expansion through one memory; bytes are taken only in idle.
// Reset: synchronous, active low; chaining value to IV, fill and length to zero.
// ----------------------------------------------------------------------------
// SM3 hash core
// Byte-stream SM3 engine with block and word memories and a shared round unit.
// ----------------------------------------------------------------------------
module sm3_hash_core (
  input  logic   clk,
  input  logic   rst_n,
  sm3_in_if.sink    in_ch,
  sm3_out_if.source out_ch
);

  sm3_pkg::state_t state_r, state_nxt;

  // Block buffer: 64 bytes, one synchronous read port.
  logic [7:0] bbuf [64];
  logic       bb_we;
  logic [5:0] bb_waddr, bb_raddr;
  logic [7:0] bb_wdata, bb_rdata_r;

  // Expanded words: 68 entries, two read ports.
  logic [31:0] wmem [68];
  logic        wm_we;
  logic [6:0]  wm_waddr, wm_ra, wm_rb;
  logic [31:0] wm_wdata, wm_qa_r, wm_qb_r;

  logic [31:0] cv_r [8];
  logic [31:0] rr_r [8];
  logic [31:0] acc_r, acc_nxt;
  logic [6:0]  fill_r, fill_nxt;
  logic [63:0] len_r, len_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic        fin_r, fin_nxt;
  logic [31:0] t3_r, t3_nxt;
  logic [2:0]  oidx_r, oidx_nxt;
  logic        cv_init, cv_fold, rr_load, rr_step;
  logic        pend_r;

  always_ff @(posedge clk) begin
    if (bb_we) bbuf[bb_waddr] <= bb_wdata;
    bb_rdata_r <= bbuf[bb_raddr];
    if (wm_we) wmem[wm_waddr] <= wm_wdata;
    wm_qa_r <= wmem[wm_ra];
    wm_qb_r <= wmem[wm_rb];
  end

  // Round datapath on the two registered memory words W[j] and W[j+4].
  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2;
  always_comb begin
    tj  = (cnt_r < 7'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
    a12 = sm3_pkg::rotl(rr_r[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + rr_r[4] + sm3_pkg::rotl(tj, cnt_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (cnt_r < 7'd16) begin
      ff = rr_r[0] ^ rr_r[1] ^ rr_r[2];
      gg = rr_r[4] ^ rr_r[5] ^ rr_r[6];
    end else begin
      ff = (rr_r[0] & rr_r[1]) | (rr_r[0] & rr_r[2]) | (rr_r[1] & rr_r[2]);
      gg = (rr_r[4] & rr_r[5]) | (~rr_r[4] & rr_r[6]);
    end
    tt1 = ff + rr_r[3] + ss2 + (wm_qa_r ^ wm_qb_r);
    tt2 = gg + rr_r[7] + ss1 + wm_qa_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sm3_pkg::ST_IDLE;
      fill_r  <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      sub_r   <= '0;
      fin_r   <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sub_r   <= sub_nxt;
      fin_r   <= fin_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    t3_r  <= t3_nxt;
    if (!rst_n || cv_init) begin
      for (int i = 0; i < 8; i++) cv_r[i] <= sm3_pkg::IV[i];
    end else if (cv_fold) begin
      for (int i = 0; i < 8; i++) cv_r[i] <= cv_r[i] ^ rr_r[i];
    end
    if (rr_load) begin
      for (int i = 0; i < 8; i++) rr_r[i] <= cv_r[i];
    end else if (rr_step) begin
      rr_r[0] <= tt1;
      rr_r[1] <= rr_r[0];
      rr_r[2] <= sm3_pkg::rotl(rr_r[1], 5'd9);
      rr_r[3] <= rr_r[2];
      rr_r[4] <= sm3_pkg::p0(tt2);
      rr_r[5] <= rr_r[4];
      rr_r[6] <= sm3_pkg::rotl(rr_r[5], 5'd19);
      rr_r[7] <= rr_r[6];
    end
  end

  logic [6:0] pad_len;

  always_comb begin
    state_nxt = state_r;
    fill_nxt  = fill_r;
    len_nxt   = len_r;
    cnt_nxt   = cnt_r;
    sub_nxt   = sub_r;
    fin_nxt   = fin_r;
    oidx_nxt  = oidx_r;
    acc_nxt   = acc_r;
    t3_nxt    = t3_r;
    bb_we = 1'b0; bb_waddr = fill_r[5:0]; bb_wdata = in_ch.data_byte;
    bb_raddr = '0;
    wm_we = 1'b0; wm_waddr = cnt_r; wm_wdata = '0;
    wm_ra = cnt_r; wm_rb = cnt_r + 7'd4;
    cv_init = 1'b0; cv_fold = 1'b0; rr_load = 1'b0; rr_step = 1'b0;
    in_ch.ready  = 1'b0;
    out_ch.valid = 1'b0;
    pad_len = fill_r + 7'd1;
    case (state_r)
      sm3_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          fin_nxt = 1'b0;
          if (in_ch.byte_valid) begin
            bb_we    = 1'b1;
            len_nxt  = len_r + 64'd8;
            fill_nxt = fill_r + 7'd1;
            if (fill_r == 7'd63) begin
              fill_nxt = '0;
              state_nxt = sm3_pkg::ST_LOAD;
              cnt_nxt = '0; sub_nxt = '0;
            end else if (in_ch.last) begin
              state_nxt = sm3_pkg::ST_PAD;
            end
          end else if (in_ch.last) begin
            state_nxt = sm3_pkg::ST_PAD;
          end
        end
      end
      sm3_pkg::ST_PAD: begin
        // Write 0x80 at the fill point, then zeros up to the length field.
        bb_we = 1'b1; bb_wdata = sm3_pkg::PAD_BYTE;
        fin_nxt = 1'b0;
        if (pad_len > 7'd56) begin
          fill_nxt = pad_len;
          state_nxt = (pad_len == 7'd64) ? sm3_pkg::ST_LOAD : sm3_pkg::ST_LEN;
          cnt_nxt = '0; sub_nxt = '0;
          // Reuse ST_LEN with sub_r=1 as a zero-filler to the end of the block.
          sub_nxt = 2'd1;
          if (pad_len == 7'd64) begin
            fill_nxt = '0; sub_nxt = '0; fin_nxt = 1'b1;
          end
        end else begin
          fill_nxt = pad_len;
          sub_nxt = 2'd0;
          state_nxt = sm3_pkg::ST_LEN;
        end
      end
      sm3_pkg::ST_LEN: begin
        bb_we = 1'b1;
        if (sub_r == 2'd1) begin
          bb_wdata = '0;
          fill_nxt = fill_r + 7'd1;
          if (fill_r == 7'd63) begin
            fill_nxt = '0; sub_nxt = '0; fin_nxt = 1'b1;
            state_nxt = sm3_pkg::ST_LOAD;
            cnt_nxt = '0;
          end
        end else begin
          if (fill_r < 7'd56) bb_wdata = '0;
          else bb_wdata = 8'(len_r >> {3'd7 - fill_r[2:0], 3'b000});
          fill_nxt = fill_r + 7'd1;
          if (fill_r == 7'd63) begin
            fill_nxt = '0; fin_nxt = 1'b0;
            oidx_nxt = 3'd1; // marks final block
            state_nxt = sm3_pkg::ST_LOAD;
            cnt_nxt = '0;
          end
        end
      end
      sm3_pkg::ST_LOAD: begin
        // Four byte reads per word; sub_r counts the read in flight.
        bb_raddr = {cnt_r[3:0], sub_r};
        if (cnt_r[4] == 1'b0) sub_nxt = sub_r + 2'd1;
        // Byte from previous cycle arrives now.
        if (t3_r[0]) acc_nxt = {acc_r[23:0], bb_rdata_r};
        t3_nxt = {31'd0, 1'b1};
        if (t3_r[0] && t3_r[1]) begin
          wm_we = 1'b1; wm_waddr = {3'd0, t3_r[5:2]};
          wm_wdata = {acc_r[23:0], bb_rdata_r};
        end
        t3_nxt[1] = (sub_r == 2'd3);
        t3_nxt[5:2] = cnt_r[3:0];
        if (sub_r == 2'd3) cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == 7'd16) begin
          t3_nxt = '0;
          cnt_nxt = 7'd16; sub_nxt = '0;
          state_nxt = sm3_pkg::ST_EXP;
        end
      end
      sm3_pkg::ST_EXP: begin
        // Sub 0..2 read pairs (j-16,j-9), (j-3,j-13), (j-6,-); sub 3 writes W[j].
        case (sub_r)
          2'd0: begin wm_ra = cnt_r - 7'd16; wm_rb = cnt_r - 7'd9; end
          2'd1: begin wm_ra = cnt_r - 7'd3;  wm_rb = cnt_r - 7'd13;
                      acc_nxt = wm_qa_r ^ wm_qb_r; end
          2'd2: begin wm_ra = cnt_r - 7'd6;  wm_rb = cnt_r - 7'd6;
                      acc_nxt = sm3_pkg::p1(acc_r ^ sm3_pkg::rotl(wm_qa_r, 5'd15));
                      t3_nxt = sm3_pkg::rotl(wm_qb_r, 5'd7); end
          default: begin
            wm_we = 1'b1;
            wm_wdata = acc_r ^ t3_r ^ wm_qa_r;
          end
        endcase
        sub_nxt = sub_r + 2'd1;
        if (sub_r == 2'd3) begin
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd67) begin
            cnt_nxt = '0; sub_nxt = '0;
            rr_load = 1'b1;
            state_nxt = sm3_pkg::ST_ROUND;
          end
        end
      end
      sm3_pkg::ST_ROUND: begin
        // sub_r=0 primes the read of W[0]/W[4]; each later cycle is a round.
        if (sub_r == 2'd0) begin
          wm_ra = 7'd0; wm_rb = 7'd4;
          sub_nxt = 2'd1;
        end else begin
          rr_step = 1'b1;
          wm_ra = cnt_r + 7'd1; wm_rb = cnt_r + 7'd5;
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd63) begin
            cnt_nxt = '0; sub_nxt = '0;
            state_nxt = sm3_pkg::ST_FOLD;
          end
        end
      end
      sm3_pkg::ST_FOLD: begin
        cv_fold = 1'b1;
        if (fin_r) begin
          fin_nxt = 1'b0;
          fill_nxt = '0; sub_nxt = '0;
          state_nxt = sm3_pkg::ST_LEN;
        end else if (oidx_r == 3'd1) begin
          oidx_nxt = '0;
          state_nxt = sm3_pkg::ST_EMIT;
        end else if (pend_r) begin
          state_nxt = sm3_pkg::ST_PAD;
        end else begin
          state_nxt = sm3_pkg::ST_IDLE;
        end
      end
      sm3_pkg::ST_EMIT: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            cv_init = 1'b1;
            fill_nxt = '0; len_nxt = '0;
            state_nxt = sm3_pkg::ST_IDLE;
          end
        end
      end
      default: state_nxt = sm3_pkg::ST_IDLE;
    endcase
  end

  // A block that fills with last set must still be padded after its fold.
  // pend_r holds that request until the padding starts.
  always_ff @(posedge clk) begin
    if (!rst_n) pend_r <= 1'b0;
    else if (state_r == sm3_pkg::ST_IDLE && in_ch.valid && in_ch.byte_valid &&
             fill_r == 7'd63) pend_r <= in_ch.last;
    else if (state_r == sm3_pkg::ST_PAD) pend_r <= 1'b0;
  end

  logic [31:0] dw;
  always_comb begin
    dw = cv_r[oidx_r];
  end
  assign out_ch.digest_word = dw;
  assign out_ch.word_index  = oidx_r;
  assign out_ch.last_word   = (oidx_r == 3'd7);

endmodule
